// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the watch mode controller RTL.
// Each macro samples on the rising edge of clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every sampled edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// When the antecedent holds, the consequent must hold in the following cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/wms_pkg.sv =====
// Shared codes and types for the watch mode controller.
// Used by wms_ctrl, wms_bcd_inc and watch_mode_and_time_set_fsm_unit; no dependencies.
`default_nettype none

package wms_pkg;

  // Event codes on the action field
  localparam logic [1:0] ACT_PRESS   = 2'd0;
  localparam logic [1:0] ACT_WAKE    = 2'd1;
  localparam logic [1:0] ACT_TIMEOUT = 2'd2;

  // Press classes
  localparam logic [1:0] PRESS_NONE  = 2'd0;
  localparam logic [1:0] PRESS_SHORT = 2'd1;
  localparam logic [1:0] PRESS_LONG  = 2'd2;
  localparam logic [1:0] PRESS_XLONG = 2'd3;

  // Mode codes as seen on the mode output
  localparam logic [3:0] MODE_SLEEP     = 4'd0;
  localparam logic [3:0] MODE_WOKE      = 4'd1;
  localparam logic [3:0] MODE_TIME      = 4'd2;
  localparam logic [3:0] MODE_DATE      = 4'd3;
  localparam logic [3:0] MODE_BATTERY   = 4'd4;
  localparam logic [3:0] MODE_SET_SEC   = 4'd5;
  localparam logic [3:0] MODE_SET_MIN   = 4'd6;
  localparam logic [3:0] MODE_SET_HOUR  = 4'd7;
  localparam logic [3:0] MODE_SET_DAY   = 4'd8;
  localparam logic [3:0] MODE_SET_MONTH = 4'd9;
  localparam logic [3:0] MODE_SET_YEAR  = 4'd10;

  // Decision for one transaction, from the mode logic to the top level
  typedef struct packed {
    logic [3:0] mode_next;
    logic       commit;
    logic       load;
    logic       bump;
  } ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/wms_ctrl.sv =====
// Next-mode decision for one event of the watch mode controller.
// Depends on wms_pkg for event, press and mode codes and the ctrl_t struct.
`default_nettype none

module wms_ctrl
  import wms_pkg::*;
(
  input  logic [3:0] mode,
  input  logic [1:0] action,
  input  logic [1:0] press_class,
  output ctrl_t      ctrl
);

  always_comb begin
    ctrl.mode_next = mode;
    ctrl.commit    = 1'b0;
    ctrl.load      = 1'b0;
    ctrl.bump      = 1'b0;
    unique case (action)
      ACT_WAKE:    ctrl.mode_next = MODE_WOKE;
      ACT_TIMEOUT: ctrl.mode_next = MODE_SLEEP;
      ACT_PRESS: begin
        ctrl.mode_next = MODE_SLEEP;
        if (press_class != PRESS_NONE) begin
          if (mode == MODE_WOKE) begin
            ctrl.mode_next = MODE_TIME;
          end else if (mode >= MODE_TIME && mode <= MODE_BATTERY) begin
            unique case (press_class)
              PRESS_SHORT: begin
                ctrl.mode_next = (mode == MODE_BATTERY) ? MODE_SLEEP : mode + 4'd1;
              end
              PRESS_LONG: ctrl.mode_next = MODE_SLEEP;
              default: begin
                ctrl.mode_next = MODE_SET_SEC;
                ctrl.load      = 1'b1;
              end
            endcase
          end else if (mode >= MODE_SET_SEC && mode <= MODE_SET_YEAR) begin
            unique case (press_class)
              PRESS_SHORT: begin
                ctrl.mode_next = mode;
                ctrl.bump      = 1'b1;
              end
              PRESS_LONG: begin
                ctrl.mode_next = (mode == MODE_SET_YEAR) ? MODE_TIME : mode + 4'd1;
              end
              default: begin
                ctrl.mode_next = MODE_TIME;
                ctrl.commit    = 1'b1;
              end
            endcase
          end
        end
      end
      default: ctrl.mode_next = mode;  // unused action code: keep the mode, raise no flag
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/wms_bcd_inc.sv =====
// BCD field increment with per-field wrap for the watch set modes.
// Depends on wms_pkg for the set-mode codes that select the wrap rule.
`default_nettype none

module wms_bcd_inc
  import wms_pkg::*;
(
  input  logic [3:0] sel,
  input  logic [6:0] field,
  output logic [7:0] bcd
);

  logic [6:0] value;
  logic [6:0] plus1;
  logic [6:0] wrapped;
  logic [6:0] base;
  logic [2:0] tens;

  // tens digit from bits 6..4, units with binary weight
  assign value = {1'b0, field[6:4], 3'b000} + {3'b000, field[6:4], 1'b0}
               + {3'b000, field[3:0]};
  assign plus1 = value + 7'd1;

  always_comb begin
    unique case (sel)
      MODE_SET_SEC, MODE_SET_MIN: begin
        wrapped = (plus1 >= 7'd60) ? plus1 - 7'd60 : plus1;
      end
      MODE_SET_HOUR: begin
        wrapped = (plus1 >= 7'd24) ? plus1 - 7'd24 : plus1;
      end
      MODE_SET_DAY: begin
        wrapped = (value >= 7'd31) ? value - 7'd30 : plus1;
      end
      MODE_SET_MONTH: begin
        priority if (value >= 7'd24) wrapped = value - 7'd23;
        else if (value >= 7'd12)     wrapped = value - 7'd11;
        else                         wrapped = plus1;
      end
      default: begin
        wrapped = (plus1 >= 7'd50) ? plus1 - 7'd50 : plus1;
      end
    endcase
  end

  // back to BCD; the wrapped value is always below 60
  always_comb begin
    priority if (wrapped >= 7'd50) begin
      tens = 3'd5; base = 7'd50;
    end else if (wrapped >= 7'd40) begin
      tens = 3'd4; base = 7'd40;
    end else if (wrapped >= 7'd30) begin
      tens = 3'd3; base = 7'd30;
    end else if (wrapped >= 7'd20) begin
      tens = 3'd2; base = 7'd20;
    end else if (wrapped >= 7'd10) begin
      tens = 3'd1; base = 7'd10;
    end else begin
      tens = 3'd0; base = 7'd0;
    end
  end

  assign bcd = {1'b0, tens, 4'(wrapped - base)};

endmodule

`default_nettype wire

// ===== rtl/core/watch_mode_and_time_set_fsm_unit.sv =====
// Top level of the one-button watch mode controller.
// Depends on wms_pkg, wms_ctrl, wms_bcd_inc and assert_macros.svh.
// Usage:
//   Input channel (in_valid/in_ready) carries one event per transaction:
//   action, press_class and the current BCD time from the clock chip.
//   Output channel (out_valid/out_ready) carries one result per event:
//   the new mode, the commit flag and the whole edit copy of the time.
//   Results are registered: an event accepted at one edge shows its result
//   at the outputs right after that edge. Throughput is one event per cycle
//   while the receiver does not stall; the mode and edit registers double as
//   the result register, with the decision and one BCD increment before it.
//   When the receiver stalls, the result holds and in_ready drops; in_ready
//   is high whenever the result slot is empty or is taken in the same cycle.
//   Reset puts the watch in sleep mode with a zero edit copy, clears
//   commit and leaves the result slot empty.
`default_nettype none

`include "assert_macros.svh"

module watch_mode_and_time_set_fsm_unit
  import wms_pkg::*;
(
  input  logic       clk,
  input  logic       rst,

  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] action,
  input  logic [1:0] press_class,
  input  logic [6:0] rtc_seconds,
  input  logic [6:0] rtc_minutes,
  input  logic [5:0] rtc_hours,
  input  logic [5:0] rtc_days,
  input  logic [2:0] rtc_weekday,
  input  logic [4:0] rtc_months,
  input  logic [7:0] rtc_years,

  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] mode,
  output logic       commit,
  output logic [6:0] edit_seconds,
  output logic [6:0] edit_minutes,
  output logic [5:0] edit_hours,
  output logic [5:0] edit_days,
  output logic [2:0] edit_weekday,
  output logic [4:0] edit_months,
  output logic [7:0] edit_years
);

  ctrl_t       ctrl;
  logic        accept;
  logic [6:0]  bump_field;
  logic [7:0]  bump_bcd;
  logic [45:0] held_state;

  // Take a new event whenever the result slot is free or drains this cycle
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  wms_ctrl u_ctrl (
    .mode        (mode),
    .action      (action),
    .press_class (press_class),
    .ctrl        (ctrl)
  );

  // Pick the field that a short press in the current set mode increments;
  // bit 7 of the year takes no part in the increment
  always_comb begin
    unique case (mode)
      MODE_SET_SEC:   bump_field = edit_seconds;
      MODE_SET_MIN:   bump_field = edit_minutes;
      MODE_SET_HOUR:  bump_field = {1'b0, edit_hours};
      MODE_SET_DAY:   bump_field = {1'b0, edit_days};
      MODE_SET_MONTH: bump_field = {2'b00, edit_months};
      default:        bump_field = edit_years[6:0];
    endcase
  end

  wms_bcd_inc u_bcd_inc (
    .sel   (mode),
    .field (bump_field),
    .bcd   (bump_bcd)
  );

  // Mode and edit copy are both state and result: advance them only on an
  // accepted transaction, so a stalled result holds as it is.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      mode         <= MODE_SLEEP;
      commit       <= 1'b0;
      edit_seconds <= '0;
      edit_minutes <= '0;
      edit_hours   <= '0;
      edit_days    <= '0;
      edit_weekday <= '0;
      edit_months  <= '0;
      edit_years   <= '0;
    end else begin
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (accept) begin
        mode   <= ctrl.mode_next;
        commit <= ctrl.commit;
        if (ctrl.load) begin
          // extra-long press in a view: copy the clock time
          edit_seconds <= rtc_seconds;
          edit_minutes <= rtc_minutes;
          edit_hours   <= rtc_hours;
          edit_days    <= rtc_days;
          edit_weekday <= rtc_weekday;
          edit_months  <= rtc_months;
          edit_years   <= rtc_years;
        end else if (ctrl.bump) begin
          // short press in a set mode: write back the incremented field
          unique case (mode)
            MODE_SET_SEC:   edit_seconds <= bump_bcd[6:0];
            MODE_SET_MIN:   edit_minutes <= bump_bcd[6:0];
            MODE_SET_HOUR:  edit_hours   <= bump_bcd[5:0];
            MODE_SET_DAY:   edit_days    <= bump_bcd[5:0];
            MODE_SET_MONTH: edit_months  <= bump_bcd[4:0];
            default:        edit_years   <= bump_bcd;
          endcase
        end
      end
    end
  end

  // Mode and edit copy packed together for the hold check
  assign held_state = {mode, edit_seconds, edit_minutes, edit_hours, edit_days,
                       edit_weekday, edit_months, edit_years};

  `ASSERT_ALWAYS(a_commit_lands_in_time, !commit || mode == MODE_TIME, "commit outside time mode")
  `ASSERT_ALWAYS(a_mode_in_range, mode <= MODE_SET_YEAR, "mode register holds an unused code")
  `ASSERT_NEXT(a_accept_fills_slot, accept, out_valid, "accepted event produced no result")
  `ASSERT_NEXT(a_edit_holds_when_idle, !accept, $stable(held_state), "state moved while idle")

endmodule

`default_nettype wire
